// ===== sv/cma_pkg.sv =====
// shared types and constants for the candle moving average block
package cma_pkg;

    localparam int PRICE_W     = 48;
    localparam int NUM_PRICES  = 4;
    localparam int PRICE_IDX_W = 2;

    typedef logic [PRICE_W-1:0] price_t;

    // reciprocal of a zero or one price saturates to all ones
    localparam price_t RECIP_SAT = {PRICE_W{1'b1}};

endpackage

// ===== sv/cma_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module cma_divider #(
    parameter int DIVIDEND_W = 54
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  cma_pkg::price_t        divisor,
    output logic                   done,
    output logic [DIVIDEND_W-1:0]  quotient
);
    import cma_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] work_reg;
    price_t                rem_reg;
    price_t                divisor_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [PRICE_W:0] shifted;
    logic [PRICE_W:0] diff;
    logic             ge;

    always_comb begin
        shifted = {rem_reg, work_reg[DIVIDEND_W-1]};
        ge      = shifted >= {1'b0, divisor_reg};
        diff    = shifted - {1'b0, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                work_reg    <= dividend;
                rem_reg     <= '0;
                divisor_reg <= divisor;
                count_reg   <= CNT_W'(DIVIDEND_W);
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                rem_reg   <= ge ? diff[PRICE_W-1:0] : shifted[PRICE_W-1:0];
                work_reg  <= {work_reg[DIVIDEND_W-2:0], ge};
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

// ===== sv/candle_moving_average.sv =====
// top level: candle inversion and short / long simple moving averages of the open price
//
// One candle is taken per request on the s_axis side and one result request
// leaves on the m_axis side. All divisions share one restoring divider that
// produces one quotient bit per cycle over a dividend of SUM_W bits
// (SUM_W = 48 + clog2(max window + 1), 54 at the default windows). In
// inverted mode each of the four prices is replaced by its reciprocal from
// the divider, while a zero or one price saturates to all ones without it.
// The first candle of a series needs no averaging division. The block takes
// no new candle until the current one is finished, but a finished result may
// wait in the output register while the next candle is already being worked
// on. invert_prices is written through the cfg port and must only change
// while the block is idle.
module candle_moving_average #(
    parameter int SHORT_WINDOW = 20,
    parameter int LONG_WINDOW  = 50
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: invert_prices
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    // candle input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // open_price, high_price, low_price, close_price, base_volume, counter_volume
    input  logic [287:0] s_axis_tdata,
    // series_start
    input  logic         s_axis_tuser,
    // result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // open_out, high_out, low_out, close_out, base_volume_out,
    // counter_volume_out, short_average, long_average
    output logic [383:0] m_axis_tdata
);
    import cma_pkg::*;

    localparam int MAX_WINDOW = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int POS_W      = $clog2(MAX_WINDOW + 2);
    localparam int POS_CAP    = MAX_WINDOW + 1;
    localparam int DVS_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = PRICE_W + $clog2(MAX_WINDOW + 1);

    localparam logic [SUM_W-1:0] ONE_SQUARED = SUM_W'(1) << PRICE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECIP,
        ST_RECIP_WAIT,
        ST_AVG_SETUP,
        ST_ADD,
        ST_SUB,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // candle under work: open, high, low, close
    price_t                 price_reg [NUM_PRICES];
    price_t                 base_reg;
    price_t                 counter_reg;
    price_t                 short_avg_reg;
    price_t                 long_avg_reg;
    logic [PRICE_IDX_W-1:0] k_reg;
    logic                   win_reg;     // 0 short window, 1 long window
    logic [POS_W-1:0]       idx_reg;     // candle index within its series

    // running state
    logic                   invert_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [PTR_W-1:0]       wp_reg;
    logic [SUM_W-1:0]       short_sum_reg;
    logic [SUM_W-1:0]       long_sum_reg;
    logic [SUM_W-1:0]       acc_reg;

    // ring of recent open prices
    price_t                 history_mem [MAX_WINDOW];
    price_t                 rd_data_reg;

    logic                   m_valid_reg;
    logic [383:0]           m_data_reg;

    // divider hookup
    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend;
    price_t                 div_divisor;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quotient;

    price_t                 cur_price;
    logic [POS_W-1:0]       win_n;
    logic                   drop_old;
    logic [DVS_W-1:0]       win_div;
    logic [SUM_W-1:0]       sum_sel;
    logic [PTR_W:0]         short_tmp;
    logic [PTR_W:0]         long_tmp;
    logic [PTR_W-1:0]       short_addr;
    logic [PTR_W-1:0]       long_addr;
    logic [PTR_W-1:0]       rd_addr;
    logic                   out_free;

    cma_divider #(
        .DIVIDEND_W (SUM_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        cur_price = price_reg[k_reg];
        win_n     = win_reg ? POS_W'(LONG_WINDOW) : POS_W'(SHORT_WINDOW);
        // past the warm-up the oldest candle leaves the window
        drop_old  = idx_reg > win_n;
        win_div   = (idx_reg < win_n) ? DVS_W'(idx_reg) : DVS_W'(win_n);
        sum_sel   = win_reg ? long_sum_reg : short_sum_reg;
        out_free  = !m_valid_reg || m_axis_tready;

        // slot of the candle that drops out of each window
        short_tmp = {1'b0, wp_reg} + (PTR_W+1)'(MAX_WINDOW - SHORT_WINDOW);
        long_tmp  = {1'b0, wp_reg} + (PTR_W+1)'(MAX_WINDOW - LONG_WINDOW);
        short_addr = (short_tmp >= (PTR_W+1)'(MAX_WINDOW))
                   ? PTR_W'(short_tmp - (PTR_W+1)'(MAX_WINDOW)) : short_tmp[PTR_W-1:0];
        long_addr  = (long_tmp >= (PTR_W+1)'(MAX_WINDOW))
                   ? PTR_W'(long_tmp - (PTR_W+1)'(MAX_WINDOW)) : long_tmp[PTR_W-1:0];
        rd_addr    = win_reg ? long_addr : short_addr;

        div_start    = 1'b0;
        div_dividend = ONE_SQUARED;
        div_divisor  = cur_price;
        case (state_reg)
            ST_RECIP: begin
                // only prices of two or more go through the divider
                div_start = cur_price[PRICE_W-1:1] != '0;
            end
            ST_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = acc_reg;
                div_divisor  = PRICE_W'(win_div);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // ring write when the result is loaded into the output register, registered read every cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            history_mem[wp_reg] <= price_reg[0];
        end
        rd_data_reg <= history_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            invert_reg    <= 1'b0;
            pos_reg       <= '0;
            wp_reg        <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            k_reg         <= '0;
            win_reg       <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                invert_reg <= cfg_data;
            end
            // a new result replaces one that leaves in the same cycle
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        price_reg[0] <= s_axis_tdata[47:0];
                        price_reg[1] <= s_axis_tdata[95:48];
                        price_reg[2] <= s_axis_tdata[143:96];
                        price_reg[3] <= s_axis_tdata[191:144];
                        if (invert_reg) begin
                            // quoted pair: volumes trade places
                            base_reg    <= s_axis_tdata[287:240];
                            counter_reg <= s_axis_tdata[239:192];
                            state_reg   <= ST_RECIP;
                        end else begin
                            base_reg    <= s_axis_tdata[239:192];
                            counter_reg <= s_axis_tdata[287:240];
                            state_reg   <= ST_AVG_SETUP;
                        end
                        idx_reg <= s_axis_tuser ? '0 : pos_reg;
                        k_reg   <= '0;
                    end
                end
                ST_RECIP: begin
                    if (cur_price[PRICE_W-1:1] == '0) begin
                        price_reg[k_reg] <= RECIP_SAT;
                        k_reg            <= k_reg + PRICE_IDX_W'(1);
                        if (k_reg == PRICE_IDX_W'(NUM_PRICES - 1)) begin
                            state_reg <= ST_AVG_SETUP;
                        end
                    end else begin
                        state_reg <= ST_RECIP_WAIT;
                    end
                end
                ST_RECIP_WAIT: begin
                    if (div_done) begin
                        price_reg[k_reg] <= div_quotient[PRICE_W-1:0];
                        k_reg            <= k_reg + PRICE_IDX_W'(1);
                        state_reg <= (k_reg == PRICE_IDX_W'(NUM_PRICES - 1))
                                   ? ST_AVG_SETUP : ST_RECIP;
                    end
                end
                ST_AVG_SETUP: begin
                    win_reg <= 1'b0;
                    if (idx_reg == '0) begin
                        // first candle of a series: averages are its own open
                        short_avg_reg <= price_reg[0];
                        long_avg_reg  <= price_reg[0];
                        short_sum_reg <= '0;
                        long_sum_reg  <= '0;
                        state_reg     <= ST_FINISH;
                    end else begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    acc_reg   <= sum_sel + SUM_W'(price_reg[0]);
                    state_reg <= ST_SUB;
                end
                ST_SUB: begin
                    if (drop_old) begin
                        acc_reg <= acc_reg - SUM_W'(rd_data_reg);
                    end
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (win_reg) begin
                            long_sum_reg <= acc_reg;
                            long_avg_reg <= div_quotient[PRICE_W-1:0];
                            state_reg    <= ST_FINISH;
                        end else begin
                            short_sum_reg <= acc_reg;
                            short_avg_reg <= div_quotient[PRICE_W-1:0];
                            win_reg       <= 1'b1;
                            state_reg     <= ST_ADD;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_data_reg  <= {long_avg_reg, short_avg_reg, counter_reg, base_reg,
                                        price_reg[3], price_reg[2], price_reg[1],
                                        price_reg[0]};
                        wp_reg      <= (wp_reg == PTR_W'(MAX_WINDOW - 1))
                                     ? '0 : wp_reg + PTR_W'(1);
                        if (idx_reg < POS_W'(POS_CAP)) begin
                            pos_reg <= idx_reg + POS_W'(1);
                        end else begin
                            pos_reg <= idx_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
